[rtl/bmpru_pkg.sv]
// ----------------------------------------------------------------------------
// bmpru_pkg: shared types and constants of the BMP row pixel unpacker
// Pixel format codes, configuration register indexes, field widths and the
// job record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package bmpru_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_WIDTH_DEF     = 4096;
    localparam int PALETTE_DEPTH_DEF = 256;

    // Field widths fixed by the interface
    localparam int BYTE_W     = 8;
    localparam int RGB_W      = 24;
    localparam int WIDTH_W    = 13;   // image_width register and pixel x
    localparam int COLUMN_W   = 12;
    localparam int POS_W      = 14;   // byte position inside a row
    localparam int CNT_W      = 4;    // pixels per byte, 0..8
    localparam int PIX_K_W    = 3;    // pixel slot inside a byte, 0..7
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b1;

    // Input item kinds
    localparam logic KIND_PALETTE = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

    typedef enum logic [1:0] {
        FMT_1BPP  = 2'd0,
        FMT_4BPP  = 2'd1,
        FMT_8BPP  = 2'd2,
        FMT_24BPP = 2'd3
    } fmt_t;

    // One unit of work for the back end: a palette write or a pixel byte
    typedef struct packed {
        logic                   is_write;
        fmt_t                   fmt;
        logic [BYTE_W-1:0]      data;     // pixel byte, or palette index
        logic [WIDTH_W-1:0]     x0;       // column of the first pixel
        logic [CNT_W-1:0]       cnt;      // pixels to emit, at least one in a pixel job
        logic                   row_end;  // last pixel closes the row
        logic [RGB_W-1:0]       rgb;      // direct colour or palette entry
    } job_t;

endpackage

[rtl/bmpru_front.sv]
// ----------------------------------------------------------------------------
// bmpru_front: configuration, row tracking and request classification
// Holds the format and width registers, walks the byte position of a row,
// assembles 24 bpp pixels, queues palette writes and bytes that emit pixels.
// ----------------------------------------------------------------------------
module bmpru_front #(
    parameter int MAX_WIDTH = bmpru_pkg::MAX_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bmpru_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bmpru_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input requests
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [7:0]                        s_data_byte,
    input  logic [7:0]                        s_palette_index,
    input  logic [7:0]                        s_palette_red,
    input  logic [7:0]                        s_palette_green,
    input  logic [7:0]                        s_palette_blue,
    // job queue
    input  logic                              q_full,
    output logic                              q_push,
    output bmpru_pkg::job_t                   q_job
);

    localparam int WW    = bmpru_pkg::WIDTH_W;
    localparam int PW    = bmpru_pkg::POS_W;
    localparam int BITSW = WW + 5;
    localparam int WMAX_I = (MAX_WIDTH < (2**WW - 1)) ? MAX_WIDTH : (2**WW - 1);
    localparam logic [WW-1:0] WMAX = WW'(WMAX_I);

    bmpru_pkg::fmt_t      fmt_reg;
    logic [WW-1:0]        width_reg;
    logic [PW-1:0]        pos_reg,   pos_next;
    logic [1:0]           phase_reg, phase_next;
    logic [PW-1:0]        x24_reg,   x24_next;
    logic [7:0]           blue_reg,  blue_next;
    logic [7:0]           green_reg, green_next;

    logic [WW-1:0]        w_eff;
    logic [BITSW-1:0]     row_bits;
    logic [BITSW:0]       bits_round;
    logic [PW+1:0]        stride;
    logic [PW:0]          pos_inc;
    logic                 wrap;
    logic [PW+2:0]        x0_wide;
    logic                 pal_active;
    logic [WW-1:0]        rem;
    logic [3:0]           per;
    logic [3:0]           n_pal;
    logic                 direct_active;
    logic                 direct_emit;
    logic                 accept;
    logic                 pixel_acc;
    logic                 cfg_wr;
    bmpru_pkg::job_t      job;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign pixel_acc = accept && (s_kind == bmpru_pkg::KIND_PIXEL);

    // Clamp the width into the supported range
    always_comb begin
        if (width_reg == '0) begin
            w_eff = WW'(1);
        end else if (width_reg > WMAX) begin
            w_eff = WMAX;
        end else begin
            w_eff = width_reg;
        end
    end

    // Row length in bits, then stride in bytes rounded up to 32-bit words
    always_comb begin
        unique case (fmt_reg)
            bmpru_pkg::FMT_1BPP:  row_bits = BITSW'(w_eff);
            bmpru_pkg::FMT_4BPP:  row_bits = BITSW'(w_eff) << 2;
            bmpru_pkg::FMT_8BPP:  row_bits = BITSW'(w_eff) << 3;
            default:              row_bits = (BITSW'(w_eff) << 4) + (BITSW'(w_eff) << 3);
        endcase
        bits_round = {1'b0, row_bits} + (BITSW+1)'(31);
        stride     = {bits_round[BITSW:5], 2'b00};
    end

    assign pos_inc = {1'b0, pos_reg} + (PW+1)'(1);
    assign wrap    = {1'b0, pos_inc} >= stride;

    // Palette modes: first column of this byte and pixel count
    always_comb begin
        unique case (fmt_reg)
            bmpru_pkg::FMT_1BPP: begin
                x0_wide = {pos_reg, 3'b000};
                per     = 4'd8;
            end
            bmpru_pkg::FMT_4BPP: begin
                x0_wide = {2'b00, pos_reg, 1'b0};
                per     = 4'd2;
            end
            default: begin
                x0_wide = {3'b000, pos_reg};
                per     = 4'd1;
            end
        endcase
        pal_active = x0_wide < (PW+3)'(w_eff);
        rem        = w_eff - x0_wide[WW-1:0];
        n_pal      = (rem >= WW'(per)) ? per : rem[3:0];
    end

    // 24 bpp: the third byte of a pixel inside the image emits it
    assign direct_active = x24_reg < PW'(w_eff);
    assign direct_emit   = direct_active && (phase_reg == 2'd2);

    // Build the job for the current request
    always_comb begin
        job          = '0;
        job.fmt      = fmt_reg;
        if (s_kind == bmpru_pkg::KIND_PALETTE) begin
            job.is_write = 1'b1;
            job.data     = s_palette_index;
            job.rgb      = {s_palette_red, s_palette_green, s_palette_blue};
        end else if (fmt_reg == bmpru_pkg::FMT_24BPP) begin
            job.data     = s_data_byte;
            job.x0       = x24_reg[WW-1:0];
            job.cnt      = direct_emit ? 4'd1 : 4'd0;
            job.row_end  = (x24_reg + PW'(1)) == PW'(w_eff);
            job.rgb      = {s_data_byte, green_reg, blue_reg};
        end else begin
            job.data     = s_data_byte;
            job.x0       = x0_wide[WW-1:0];
            job.cnt      = pal_active ? n_pal : 4'd0;
            job.row_end  = (rem == WW'(n_pal));
        end
    end

    assign q_job  = job;
    assign q_push = accept && (job.is_write || (job.cnt != '0));

    // Advance the row position state
    always_comb begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        x24_next   = x24_reg;
        blue_next  = blue_reg;
        green_next = green_reg;
        if (cfg_wr) begin
            pos_next   = '0;
            phase_next = '0;
            x24_next   = '0;
            blue_next  = '0;
            green_next = '0;
        end else if (pixel_acc) begin
            if (fmt_reg == bmpru_pkg::FMT_24BPP && direct_active) begin
                if (phase_reg == 2'd0) begin
                    blue_next = s_data_byte;
                end else if (phase_reg == 2'd1) begin
                    green_next = s_data_byte;
                end
                phase_next = (phase_reg == 2'd2) ? 2'd0 : phase_reg + 2'd1;
                x24_next   = (phase_reg == 2'd2) ? x24_reg + PW'(1) : x24_reg;
            end
            if (wrap) begin
                pos_next   = '0;
                phase_next = '0;
                x24_next   = '0;
            end else begin
                pos_next   = pos_inc[PW-1:0];
            end
        end
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg   <= bmpru_pkg::FMT_24BPP;
            width_reg <= WW'(1);
            pos_reg   <= '0;
            phase_reg <= '0;
            x24_reg   <= '0;
            blue_reg  <= '0;
            green_reg <= '0;
        end else begin
            if (cfg_wr && cfg_index == bmpru_pkg::CFG_PIXEL_FORMAT) begin
                fmt_reg <= bmpru_pkg::fmt_t'(cfg_data[1:0]);
            end
            if (cfg_wr && cfg_index == bmpru_pkg::CFG_IMAGE_WIDTH) begin
                width_reg <= cfg_data[WW-1:0];
            end
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            x24_reg   <= x24_next;
            blue_reg  <= blue_next;
            green_reg <= green_next;
        end
    end

endmodule

[rtl/bmpru_queue.sv]
// ----------------------------------------------------------------------------
// bmpru_queue: job queue between front and back end
// A small register FIFO so that request intake and pixel output stall
// independently of each other.
// ----------------------------------------------------------------------------
module bmpru_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  bmpru_pkg::job_t   push_job,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output bmpru_pkg::job_t   head_job
);

    localparam int DEPTH = bmpru_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bmpru_pkg::job_t     entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic                do_push, do_pop;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Step a pointer with wrap at the queue depth
    function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] ptr);
        step_ptr = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    always_comb begin
        wr_ptr_next = do_push ? step_ptr(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? step_ptr(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[rtl/bmpru_back.sv]
// ----------------------------------------------------------------------------
// bmpru_back: palette store and pixel emission
// Executes jobs from the queue: palette writes go to the colour memory, pixel
// bytes go one pixel per cycle, unless stalled, via a registered palette read.
// ----------------------------------------------------------------------------
module bmpru_back #(
    parameter int PALETTE_DEPTH = bmpru_pkg::PALETTE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // job queue
    input  logic              head_valid,
    input  bmpru_pkg::job_t   head_job,
    output logic              pop,
    // results
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_red,
    output logic [7:0]        m_green,
    output logic [7:0]        m_blue,
    output logic [11:0]       m_column,
    output logic              m_row_end,
    output logic              m_last
);

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int KW = bmpru_pkg::PIX_K_W;
    localparam int WW = bmpru_pkg::WIDTH_W;
    localparam int CW = bmpru_pkg::CNT_W;

    logic [bmpru_pkg::RGB_W-1:0]  palette_mem [PALETTE_DEPTH];
    logic [bmpru_pkg::RGB_W-1:0]  rd_data_reg;

    logic [KW-1:0]                k_reg, k_next;
    logic                         valid_reg, valid_next;
    logic                         direct_reg;
    logic                         in_range_reg;
    logic [bmpru_pkg::RGB_W-1:0]  rgb_reg;
    logic [WW-1:0]                column_reg;
    logic                         row_end_reg;
    logic                         last_reg;

    logic                         advance;
    logic                         pix_go;
    logic                         pix_last;
    logic [7:0]                   idx;
    logic                         idx_in_range;
    logic                         wr_go;

    assign advance  = !valid_reg || m_ready;
    assign wr_go    = head_valid && head_job.is_write;
    assign pix_go   = head_valid && !head_job.is_write && advance;
    assign pix_last = ({1'b0, k_reg} == head_job.cnt - CW'(1));
    assign pop      = wr_go || (pix_go && pix_last);

    // Select the palette index of pixel k, most significant bits first
    always_comb begin
        unique case (head_job.fmt)
            bmpru_pkg::FMT_1BPP: idx = {7'd0, head_job.data[3'd7 - k_reg]};
            bmpru_pkg::FMT_4BPP: idx = (k_reg == '0) ? {4'd0, head_job.data[7:4]}
                                                     : {4'd0, head_job.data[3:0]};
            default:             idx = head_job.data;
        endcase
        idx_in_range = {1'b0, idx} < 9'(PALETTE_DEPTH);
    end

    // Pixel counter inside the current byte
    always_comb begin
        k_next = k_reg;
        if (pix_go) begin
            k_next = pix_last ? '0 : k_reg + KW'(1);
        end
        valid_next = advance ? pix_go : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg     <= '0;
            valid_reg <= 1'b0;
        end else begin
            k_reg     <= k_next;
            valid_reg <= valid_next;
        end
    end

    // Load the output stage when it advances
    always_ff @(posedge aclk) begin
        if (pix_go) begin
            direct_reg   <= head_job.fmt == bmpru_pkg::FMT_24BPP;
            in_range_reg <= idx_in_range;
            rgb_reg      <= head_job.rgb;
            column_reg   <= head_job.x0 + WW'(k_reg);
            last_reg     <= pix_last;
            row_end_reg  <= pix_last && head_job.row_end;
        end
    end

    // Palette memory: write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_go && ({1'b0, head_job.data} < 9'(PALETTE_DEPTH))) begin
            palette_mem[head_job.data[AW-1:0]] <= head_job.rgb;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_go) begin
            rd_data_reg <= palette_mem[idx[AW-1:0]];
        end
    end

    // Drive the result channel
    always_comb begin
        m_valid   = valid_reg;
        m_column  = column_reg[11:0];
        m_row_end = row_end_reg;
        m_last    = last_reg;
        if (direct_reg) begin
            {m_red, m_green, m_blue} = rgb_reg;
        end else if (in_range_reg) begin
            {m_red, m_green, m_blue} = rd_data_reg;
        end else begin
            {m_red, m_green, m_blue} = '0;
        end
    end

endmodule

[rtl/bmp_row_pixel_unpacker_unit.sv]
// ----------------------------------------------------------------------------
// bmp_row_pixel_unpacker_unit: BMP pixel row decoder, 1/4/8/24 bpp
// Turns pixel array bytes and palette writes into RGB pixels with column.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  : register writes (index 0 pixel format, 1 image width); always
//            ready. A write restarts the row; the palette is kept.
//   s_*    : requests. kind 0 writes one palette entry, kind 1 carries the
//            next pixel array byte in file order, row padding included.
//   m_*    : decoded pixels, with column, row_end and last (final pixel of
//            the byte that caused it). Padding produces nothing.
// Path: with an idle back end an accepted byte is written into the job queue
//   and its first pixel is then loaded into the registered output stage.
// Throughput: the back end emits one pixel per cycle while m_ready allows.
//   A byte yields up to 8 pixels at 1 bpp, up to 2 at 4 bpp, 1 at 8 bpp;
//   24 bpp yields one pixel per three bytes. A pixel-less byte never reaches
//   the back end. The single palette read port sets this rate.
// Stall: a two-entry job queue lets requests keep flowing while m_ready is
//   low until the queue fills; the output stage holds its pixel meanwhile.
// Reset: format 24 bpp, width 1, row restarted. Palette contents are not
//   cleared and must be written before they are referenced.
// ----------------------------------------------------------------------------
module bmp_row_pixel_unpacker_unit #(
    parameter int MAX_WIDTH     = bmpru_pkg::MAX_WIDTH_DEF,
    parameter int PALETTE_DEPTH = bmpru_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bmpru_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bmpru_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [7:0]                        s_data_byte,
    input  logic [7:0]                        s_palette_index,
    input  logic [7:0]                        s_palette_red,
    input  logic [7:0]                        s_palette_green,
    input  logic [7:0]                        s_palette_blue,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7:0]                        m_red,
    output logic [7:0]                        m_green,
    output logic [7:0]                        m_blue,
    output logic [11:0]                       m_column,
    output logic                              m_row_end,
    output logic                              m_last
);

    logic             q_full;
    logic             q_push;
    bmpru_pkg::job_t  q_job;
    logic             q_pop;
    logic             q_head_valid;
    bmpru_pkg::job_t  q_head_job;

    // Classify requests and track the row
    bmpru_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_data_byte     (s_data_byte),
        .s_palette_index (s_palette_index),
        .s_palette_red   (s_palette_red),
        .s_palette_green (s_palette_green),
        .s_palette_blue  (s_palette_blue),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_job           (q_job)
    );

    // Decouple intake from emission
    bmpru_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    // Palette store and pixel output
    bmpru_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_red      (m_red),
        .m_green    (m_green),
        .m_blue     (m_blue),
        .m_column   (m_column),
        .m_row_end  (m_row_end),
        .m_last     (m_last)
    );

endmodule

[rtl/bmpru_checker.sv]
// ----------------------------------------------------------------------------
// bmpru_checker: port-level checks for the BMP row pixel unpacker
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module bmpru_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [11:0] m_column,
    input logic        m_row_end,
    input logic        m_last
);

    // Hold a stalled pixel
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_column))
        else $error("stalled pixel dropped or changed");

    // Close a row only on the final pixel of a byte
    a_row_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_row_end |-> m_last)
        else $error("row end on a pixel that is not the last of its byte");

    // Emit the rest of a byte without gaps
    a_byte_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("gap inside the pixels of one byte");

    // Clear the output on reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind bmp_row_pixel_unpacker_unit bmpru_checker u_bmpru_checker (.*);
